@@ src/mmds_pkg.sv @@
package mmds_pkg;

   localparam int SAMPLE_BITS   = 24;
   localparam int FRACTION_BITS = 20;
   localparam int DRIVE_BITS    = 17;
   localparam int MODE_BITS     = 3;
   localparam int Q16_SHIFT     = 16;

   localparam int MUL_W     = 48;
   localparam int CAP_BIT   = 45;
   localparam int OVF_BIT   = 64;
   localparam int CORDIC_W  = 34;
   localparam int CORDIC_STEPS = 32;

   localparam logic [MODE_BITS-1:0] MODE_CLIP  = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_POLY  = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_ATAN  = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_CUBIC = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_FUZZ  = 3'd4;

   localparam logic CSR_DRIVE = 1'b0;
   localparam logic CSR_MODE  = 1'b1;

   localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

   function automatic logic signed [CORDIC_W-1:0] atan_angle(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      atan_angle = $signed({2'b00, v});
   endfunction

endpackage

@@ src/mmds_mulq.sv @@
module mmds_mulq #(
   parameter int SHIFT = 20
) (
   input  logic                               clock,
   input  logic                               enable,
   input  logic signed [mmds_pkg::MUL_W-1:0]  a,
   input  logic signed [mmds_pkg::MUL_W-1:0]  b,
   output logic signed [mmds_pkg::MUL_W-1:0]  p
);
   import mmds_pkg::*;

   localparam int HALF = MUL_W / 2;
   localparam int PW   = 2 * MUL_W;
   localparam logic [PW-1:0] CAP = PW'(1) << CAP_BIT;

   logic [MUL_W-1:0] am, bm;
   logic [MUL_W-1:0] hh_ff, hl_ff, lh_ff, ll_ff;
   logic             neg1_ff, neg2_ff;
   logic [PW-1:0]    full_ff, full_in, shifted;
   logic [MUL_W-1:0] mag;
   logic             ovf;

   assign am = a[MUL_W-1] ? (~$unsigned(a) + 1'b1) : $unsigned(a);
   assign bm = b[MUL_W-1] ? (~$unsigned(b) + 1'b1) : $unsigned(b);

   assign full_in = (PW'(hh_ff) << MUL_W) + (PW'(hl_ff) << HALF) + (PW'(lh_ff) << HALF)
                  + PW'(ll_ff);

   assign shifted = full_ff >> SHIFT;
   assign ovf     = |full_ff[PW-1:OVF_BIT];
   assign mag     = (ovf || shifted > CAP) ? CAP[MUL_W-1:0] : shifted[MUL_W-1:0];

   always_ff @(posedge clock) begin
      if (enable) begin
         hh_ff   <= am[MUL_W-1:HALF] * bm[MUL_W-1:HALF];
         hl_ff   <= am[MUL_W-1:HALF] * bm[HALF-1:0];
         lh_ff   <= am[HALF-1:0] * bm[MUL_W-1:HALF];
         ll_ff   <= am[HALF-1:0] * bm[HALF-1:0];
         neg1_ff <= a[MUL_W-1] ^ b[MUL_W-1];
         full_ff <= full_in;
         neg2_ff <= neg1_ff;
         p       <= neg2_ff ? -$signed(mag) : $signed(mag);
      end
   end

endmodule

@@ src/multi_mode_distortion_shaper.sv @@
// Waveshaper for one signed Q3.20 audio sample per item.
// The req_ channel carries one input sample per item; the rsp_ channel returns
// the shaped, saturated sample in rsp_tdata and the saturation flag in rsp_tuser.
// The csr_ channel writes drive_amount (index 0) and shape_mode (index 1); it is
// always ready and should only be written while no items are in flight.
// Throughput is one item per clock while the output buffer has room. An item's
// result reaches the rsp_ channel through a result line whose length is set by
// the 32-stage CORDIC arctan pipeline, which all curves share in length; the other
// curves ride along a common result line.
// Reset clears the configuration registers, empties the pipeline and the output buffer.
// A two-entry output buffer sits behind the pipeline. When the receiver stalls
// the pipeline keeps moving until the buffer is full and then holds every stage
// in place, so req_tready drops without losing or repeating any item.
module multi_mode_distortion_shaper (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [mmds_pkg::SAMPLE_BITS-1:0]     req_tdata,   // in_sample
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mmds_pkg::SAMPLE_BITS-1:0]     rsp_tdata,   // out_sample
   output logic [0:0]                           rsp_tuser,   // clipped_flag
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [0:0]                           csr_index,
   input  logic [mmds_pkg::DRIVE_BITS-1:0]      csr_data
);
   import mmds_pkg::*;

   localparam int POLY_DONE  = 10;
   localparam int CUBIC_DONE = 12;
   localparam int CLIP_DONE  = 23;
   localparam int FUZZ_DONE  = 29;
   localparam int LAST_STAGE = 37;
   localparam int CUBE_UNITS = 3;
   localparam int QUO_BITS   = 21;
   localparam int REM_W      = QUO_BITS + Q16_SHIFT;
   localparam int K_W        = 21;
   localparam int CLAMP_W    = SAMPLE_BITS + 1;
   localparam int PROD3_W    = 57;

   localparam logic signed [MUL_W-1:0] ONE_W    = MUL_W'(1) << FRACTION_BITS;
   localparam logic signed [CORDIC_W-1:0] ONE_C = CORDIC_W'(1) << FRACTION_BITS;
   localparam logic signed [CORDIC_W-1:0] ANG_HALF = CORDIC_W'(1) << (29 - FRACTION_BITS);
   localparam logic signed [MUL_W-1:0] SAT_HI   = (MUL_W'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam logic signed [MUL_W-1:0] SAT_LO   = -(MUL_W'(1) << (SAMPLE_BITS - 1));
   localparam logic signed [MUL_W-1:0] FUZZ_OVER = MUL_W'(1) << SAMPLE_BITS;
   localparam logic [MUL_W-1:0] FUZZ_POS_LIM = MUL_W'(3) << (SAMPLE_BITS - 1);
   localparam logic [MUL_W-1:0] FUZZ_NEG_LIM = (MUL_W'(3) << (SAMPLE_BITS - 1)) + 3;
   localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;
   localparam logic [K_W-1:0] Q16_ONE   = K_W'(65536);
   localparam logic [K_W-1:0] POINT3    = K_W'(19661);

   logic [DRIVE_BITS-1:0] drive_ff;
   logic [MODE_BITS-1:0]  mode_ff;

   logic adv, push, pop;
   logic vld_ff [0:LAST_STAGE];
   logic signed [MUL_W-1:0] res_ff [0:LAST_STAGE];
   logic signed [MUL_W-1:0] res_in [1:LAST_STAGE];

   logic [K_W-1:0] k2, k3, k4, ksel;
   logic signed [MUL_W-1:0] sq_p, cu_p, dr_p, kz_p, kz_neg;

   logic signed [CORDIC_W-1:0] cx_ff [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] cy_ff [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] ca_ff [0:CORDIC_STEPS];
   logic                       cz_ff [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] at_rnd, at_y;

   logic signed [MUL_W-1:0] cb_in     [0:CUBE_UNITS-1];
   logic signed [MUL_W-1:0] cb_c1     [0:CUBE_UNITS-1];
   logic signed [MUL_W-1:0] cb_c2     [0:CUBE_UNITS-1];
   logic signed [MUL_W-1:0] cb_out_ff [0:CUBE_UNITS-1];
   logic signed [MUL_W-1:0] cb_tv_ff  [0:CUBE_UNITS-1][0:3];
   logic                    cb_ng_ff  [0:CUBE_UNITS-1][0:6];

   logic [DRIVE_BITS-1:0]     c17;
   logic signed [CLAMP_W-1:0] cl_x, cl_cf, cl_v;
   logic [CLAMP_W-1:0]        cl_mag;
   logic [REM_W-1:0]    dr_ff [0:QUO_BITS];
   logic [QUO_BITS-1:0] dq_ff [0:QUO_BITS];
   logic                dn_ff [0:QUO_BITS];
   logic                dz_ff [0:QUO_BITS];
   logic [REM_W-1:0]    dtrial [0:QUO_BITS-1];
   logic                dge    [0:QUO_BITS-1];
   logic signed [MUL_W-1:0] clip_q;

   logic signed [MUL_W-1:0] fz_c, fz_q;
   logic [MUL_W-1:0]        fz_m;
   logic                    fz_neg, fz_big;
   logic [PROD3_W-1:0]      fz_prod_ff;
   logic                    fz_neg_ff, fz_big_ff;

   logic [1:0]              cnt_ff;
   logic [SAMPLE_BITS-1:0]  ent_ff [0:1];
   logic                    flag_ff [0:1];
   logic signed [MUL_W-1:0] fin_y;
   logic [SAMPLE_BITS-1:0]  sat_sample;
   logic                    sat_flag;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff <= '0;
         mode_ff  <= MODE_CLIP;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DRIVE: drive_ff <= csr_data;
            CSR_MODE:  mode_ff  <= csr_data[MODE_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign k2   = Q16_ONE + K_W'({drive_ff, 2'b00});
   assign k3   = POINT3 + ((K_W'(drive_ff) * K_W'(9)) >> 1);
   assign k4   = POINT3 + K_W'({drive_ff, 1'b0});
   assign ksel = (mode_ff == MODE_ATAN) ? k2 : ((mode_ff == MODE_FUZZ) ? k4 : k3);

   // Stage advance and valid line.
   assign adv        = (cnt_ff != 2'd2);
   assign req_tready = adv;
   assign push       = adv && vld_ff[LAST_STAGE];
   assign pop        = (cnt_ff != 2'd0) && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t <= LAST_STAGE; t++) vld_ff[t] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int t = 1; t <= LAST_STAGE; t++) vld_ff[t] <= vld_ff[t-1];
      end
   end

   // Result line: carries the sample and takes each curve's result where it finishes.
   always_comb begin
      for (int t = 1; t <= LAST_STAGE; t++) res_in[t] = res_ff[t-1];
      if (mode_ff == MODE_POLY)  res_in[POLY_DONE]  = res_ff[POLY_DONE-1] - dr_p;
      if (mode_ff == MODE_CUBIC) res_in[CUBIC_DONE] = cb_out_ff[0];
      if (mode_ff == MODE_CLIP)  res_in[CLIP_DONE]  = clip_q;
      if (mode_ff == MODE_FUZZ)  res_in[FUZZ_DONE]  = fz_q;
      if (mode_ff == MODE_ATAN) begin
         res_in[LAST_STAGE] = cz_ff[CORDIC_STEPS] ? '0
                            : {{(MUL_W-CORDIC_W){at_y[CORDIC_W-1]}}, at_y};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff[0] <= {{(MUL_W-SAMPLE_BITS){req_tdata[SAMPLE_BITS-1]}}, req_tdata};
         for (int t = 1; t <= LAST_STAGE; t++) res_ff[t] <= res_in[t];
      end
   end

   // Polynomial curve.
   mmds_mulq #(.SHIFT(FRACTION_BITS)) u_mul_sq (
      .clock(clock), .enable(adv), .a(res_ff[0]), .b(res_ff[0]), .p(sq_p));
   mmds_mulq #(.SHIFT(FRACTION_BITS)) u_mul_cu (
      .clock(clock), .enable(adv), .a(sq_p), .b(res_ff[3]), .p(cu_p));
   mmds_mulq #(.SHIFT(Q16_SHIFT)) u_mul_dr (
      .clock(clock), .enable(adv), .a(cu_p), .b($signed(MUL_W'(drive_ff))), .p(dr_p));

   // Drive scaling shared by the arctan, cubic and fuzz curves.
   mmds_mulq #(.SHIFT(Q16_SHIFT)) u_mul_k (
      .clock(clock), .enable(adv), .a(res_ff[0]), .b($signed(MUL_W'(ksel))), .p(kz_p));

   // Arctan by CORDIC vectoring after a quarter-turn pre-rotation.
   assign kz_neg = -kz_p;
   assign at_rnd = ca_ff[CORDIC_STEPS] + ANG_HALF;
   assign at_y   = at_rnd >>> (30 - FRACTION_BITS);

   always_ff @(posedge clock) begin
      if (adv) begin
         cz_ff[0] <= (kz_p == '0);
         if (!kz_p[MUL_W-1] && kz_p != '0) begin
            cx_ff[0] <= $signed(kz_p[CORDIC_W-1:0]);
            cy_ff[0] <= -ONE_C;
            ca_ff[0] <= HALF_PI_Q30;
         end else begin
            cx_ff[0] <= $signed(kz_neg[CORDIC_W-1:0]);
            cy_ff[0] <= ONE_C;
            ca_ff[0] <= -HALF_PI_Q30;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            cz_ff[i+1] <= cz_ff[i];
            if (!cy_ff[i][CORDIC_W-1] && cy_ff[i] != '0) begin
               cx_ff[i+1] <= cx_ff[i] + (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] - (cx_ff[i] >>> i);
               ca_ff[i+1] <= ca_ff[i] + atan_angle(5'(i));
            end else begin
               cx_ff[i+1] <= cx_ff[i] - (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] + (cx_ff[i] >>> i);
               ca_ff[i+1] <= ca_ff[i] - atan_angle(5'(i));
            end
         end
      end
   end

   // Piecewise cubic units; the first serves the cubic curve, all three the fuzz curve.
   always_comb begin
      cb_in[0] = kz_p;
      for (int j = 1; j < CUBE_UNITS; j++) cb_in[j] = cb_out_ff[j-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < CUBE_UNITS; j++) begin
            cb_ng_ff[j][0] <= cb_in[j][MUL_W-1];
            cb_tv_ff[j][0] <= cb_in[j][MUL_W-1] ? cb_in[j] + ONE_W : cb_in[j] - ONE_W;
            for (int s = 1; s < 4; s++) cb_tv_ff[j][s] <= cb_tv_ff[j][s-1];
            for (int s = 1; s < 7; s++) cb_ng_ff[j][s] <= cb_ng_ff[j][s-1];
            cb_out_ff[j] <= cb_ng_ff[j][6] ? cb_c2[j] - ONE_W : cb_c2[j] + ONE_W;
         end
      end
   end

   for (genvar j = 0; j < CUBE_UNITS; j++) begin : g_cube
      mmds_mulq #(.SHIFT(FRACTION_BITS)) u_mul_sq (
         .clock(clock), .enable(adv), .a(cb_tv_ff[j][0]), .b(cb_tv_ff[j][0]),
         .p(cb_c1[j]));
      mmds_mulq #(.SHIFT(FRACTION_BITS)) u_mul_cu (
         .clock(clock), .enable(adv), .a(cb_c1[j]), .b(cb_tv_ff[j][3]), .p(cb_c2[j]));
   end

   // Fuzz: divide by three through a reciprocal once the value is known to be in range.
   assign fz_c   = cb_out_ff[CUBE_UNITS-1];
   assign fz_neg = fz_c[MUL_W-1];
   assign fz_m   = fz_neg ? $unsigned(-fz_c) : $unsigned(fz_c);
   assign fz_big = fz_neg ? (fz_m >= FUZZ_NEG_LIM) : (fz_m >= FUZZ_POS_LIM);

   always_ff @(posedge clock) begin
      if (adv) begin
         fz_prod_ff <= PROD3_W'(fz_m[24:0]) * PROD3_W'(RECIP3);
         fz_neg_ff  <= fz_neg;
         fz_big_ff  <= fz_big;
      end
   end

   always_comb begin
      if (fz_big_ff) begin
         fz_q = fz_neg_ff ? -FUZZ_OVER : FUZZ_OVER;
      end else begin
         fz_q = $signed(MUL_W'(fz_prod_ff[PROD3_W-1:33]));
         if (fz_neg_ff) fz_q = -fz_q;
      end
   end

   // Digital clip: clamp, then restoring division by the clip level, one bit a stage.
   assign c17    = DRIVE_BITS'(Q16_ONE - K_W'(drive_ff));
   assign cl_x   = {res_ff[0][SAMPLE_BITS-1], res_ff[0][SAMPLE_BITS-1:0]};
   assign cl_cf  = $signed({{(CLAMP_W-DRIVE_BITS-(FRACTION_BITS-Q16_SHIFT)){1'b0}},
                            c17, {(FRACTION_BITS-Q16_SHIFT){1'b0}}});

   always_comb begin
      if (cl_x > cl_cf) cl_v = cl_cf;
      else if (cl_x < -cl_cf) cl_v = -cl_cf;
      else cl_v = cl_x;
      cl_mag = cl_v[CLAMP_W-1] ? $unsigned(-cl_v) : $unsigned(cl_v);
      for (int k = 0; k < QUO_BITS; k++) begin
         dtrial[k] = REM_W'(c17) << (QUO_BITS - 1 - k);
         dge[k]    = (dr_ff[k] >= dtrial[k]);
      end
      clip_q = $signed(MUL_W'(dq_ff[QUO_BITS]));
      if (dz_ff[QUO_BITS]) clip_q = '0;
      else if (dn_ff[QUO_BITS]) clip_q = -clip_q;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dr_ff[0] <= {cl_mag[QUO_BITS-1:0], {Q16_SHIFT{1'b0}}};
         dq_ff[0] <= '0;
         dn_ff[0] <= cl_v[CLAMP_W-1];
         dz_ff[0] <= drive_ff[DRIVE_BITS-1];
         for (int k = 0; k < QUO_BITS; k++) begin
            dr_ff[k+1] <= dge[k] ? dr_ff[k] - dtrial[k] : dr_ff[k];
            dq_ff[k+1] <= dq_ff[k] | (dge[k] ? (QUO_BITS'(1) << (QUO_BITS - 1 - k)) : '0);
            dn_ff[k+1] <= dn_ff[k];
            dz_ff[k+1] <= dz_ff[k];
         end
      end
   end

   // Final saturation and the two-entry output buffer.
   assign fin_y = res_ff[LAST_STAGE];

   always_comb begin
      if (fin_y > SAT_HI) begin
         sat_sample = SAT_HI[SAMPLE_BITS-1:0];
         sat_flag   = 1'b1;
      end else if (fin_y < SAT_LO) begin
         sat_sample = SAT_LO[SAMPLE_BITS-1:0];
         sat_flag   = 1'b1;
      end else begin
         sat_sample = fin_y[SAMPLE_BITS-1:0];
         sat_flag   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (pop && !push) begin
         ent_ff[0]  <= ent_ff[1];
         flag_ff[0] <= flag_ff[1];
      end else if (push) begin
         if (cnt_ff == 2'd0 || pop) begin
            ent_ff[0]  <= sat_sample;
            flag_ff[0] <= sat_flag;
         end else begin
            ent_ff[1]  <= sat_sample;
            flag_ff[1] <= sat_flag;
         end
      end
   end

   assign rsp_tvalid   = (cnt_ff != 2'd0);
   assign rsp_tdata    = ent_ff[0];
   assign rsp_tuser[0] = flag_ff[0];

endmodule

@@ dv/tb_multi_mode_distortion_shaper.sv @@
module tb_multi_mode_distortion_shaper;
   import mmds_pkg::*;

   localparam int LATENCY = 39;
   localparam longint SAT_CAP = 64'sd1 << CAP_BIT;
   localparam longint SAMPLE_ONE = 64'sd1 << FRACTION_BITS;
   localparam longint SAMPLE_HI = (64'sd1 << (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_LO = -(64'sd1 << (SAMPLE_BITS - 1));
   localparam longint DRIVE_ONE = 64'sd65536;
   localparam longint POINT3 = 64'sd19661;
   localparam int MODE_SPARE = 5;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   clipped;
   } shaped_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [SAMPLE_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [SAMPLE_BITS-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [0:0] csr_index = '0;
   logic [DRIVE_BITS-1:0] csr_data = '0;

   logic [DRIVE_BITS-1:0] drive_reg;
   logic [MODE_BITS-1:0] mode_reg;
   shaped_type expected_shapes[$];
   int mismatches = 0;
   int stall_left = 0;
   bit sender_idles = 1'b1;
   bit receiver_idles = 1'b1;

   always #1 clock = ~clock;

   multi_mode_distortion_shaper dut (.*);

   function automatic longint scaled_product(longint a, longint b, int sh);
      bit neg;
      logic [127:0] full, p;
      longint ua, ub;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      full = 128'(ua) * 128'(ub);
      if (full[127:64] != '0) p = 128'(SAT_CAP);
      else p = full >> sh;
      if (p > 128'(SAT_CAP)) p = 128'(SAT_CAP);
      return neg ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint cubic_bend(longint s);
      longint t, c;
      t = s < 0 ? s + SAMPLE_ONE : s - SAMPLE_ONE;
      c = scaled_product(scaled_product(t, t, FRACTION_BITS), t, FRACTION_BITS);
      return s < 0 ? c - SAMPLE_ONE : c + SAMPLE_ONE;
   endfunction

   function automatic longint cordic_arctan(longint z);
      longint x, y, ang, nx, xs, ys;
      x = SAMPLE_ONE;
      y = z;
      if (y > 0) begin
         nx = y; y = -x; x = nx; ang = HALF_PI_Q30;
      end else if (y < 0) begin
         nx = -y; y = x; x = nx; ang = -HALF_PI_Q30;
      end else begin
         return 0;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; ang += atan_angle(i[4:0]);
         end else begin
            x -= ys; y += xs; ang -= atan_angle(i[4:0]);
         end
      end
      return (ang + (64'sd1 << (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
   endfunction

   function automatic shaped_type shape_sample(logic [SAMPLE_BITS-1:0] raw);
      longint x, d, y, c16, cf, v;
      shaped_type r;
      x = longint'($signed(raw));
      d = longint'(drive_reg);
      r.clipped = 1'b0;
      case (mode_reg)
         MODE_CLIP: begin
            c16 = DRIVE_ONE - d;
            if (c16 <= 0) y = 0;
            else begin
               cf = (c16 << FRACTION_BITS) >> Q16_SHIFT;
               v = x > cf ? cf : (x < -cf ? -cf : x);
               y = (v * DRIVE_ONE) / c16;
            end
         end
         MODE_POLY: y = x - scaled_product(scaled_product(scaled_product(x, x,
            FRACTION_BITS), x, FRACTION_BITS), d, Q16_SHIFT);
         MODE_ATAN: y = cordic_arctan(scaled_product(x, DRIVE_ONE + 4 * d, Q16_SHIFT));
         MODE_CUBIC: y = cubic_bend(scaled_product(x, POINT3 + (9 * d) / 2, Q16_SHIFT));
         MODE_FUZZ: y = cubic_bend(cubic_bend(cubic_bend(
            scaled_product(x, POINT3 + 2 * d, Q16_SHIFT)))) / 3;
         default: y = x;
      endcase
      if (y > SAMPLE_HI) begin
         y = SAMPLE_HI; r.clipped = 1'b1;
      end else if (y < SAMPLE_LO) begin
         y = SAMPLE_LO; r.clipped = 1'b1;
      end
      r.sample = y[SAMPLE_BITS-1:0];
      return r;
   endfunction

   task automatic write_register(logic [0:0] index, logic [DRIVE_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_DRIVE) drive_reg = value;
      else drive_reg = drive_reg;
      if (index == CSR_MODE) mode_reg = value[MODE_BITS-1:0];
   endtask

   task automatic send_sample(logic [SAMPLE_BITS-1:0] value);
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
      expected_shapes.push_back(shape_sample(value));
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (expected_shapes.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic set_shape(int mode, logic [DRIVE_BITS-1:0] drive);
      drain_pipeline();
      write_register(CSR_MODE, DRIVE_BITS'(mode));
      write_register(CSR_DRIVE, drive);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(0, 3))
         0: return SAMPLE_BITS'($urandom);
         1: return SAMPLE_BITS'($signed($urandom_range(0, 2 * SAMPLE_ONE)) - SAMPLE_ONE);
         2: return SAMPLE_BITS'($signed($urandom_range(0, 4096)) - 2048);
         default: return {$urandom_range(0, 1) ? 4'hF : 4'h0, 20'($urandom)};
      endcase
   endfunction

   task automatic test_directed();
      logic [SAMPLE_BITS-1:0] edges[8] = '{24'h7FFFFF, 24'h800000, 24'h000000,
         24'h100000, 24'hF00000, 24'h000001, 24'hFFFFFF, 24'h555555};
      int modes[4] = '{MODE_CLIP, MODE_ATAN, MODE_FUZZ, MODE_SPARE};
      logic [DRIVE_BITS-1:0] drives[4] = '{17'd0, 17'd65536, 17'd131071, 17'd32768};
      foreach (edges[i]) send_sample(edges[i]);
      for (int k = 0; k < 4; k++) begin
         set_shape(modes[k], drives[k]);
         send_sample(edges[k]);
         send_sample(edges[k + 4]);
      end
      set_shape(MODE_POLY, 17'd65535);
      send_sample(24'h7FFFFF);
      send_sample(24'h0AAAAA);
      set_shape(MODE_CUBIC, 17'd131071);
      send_sample(24'h800000);
      send_sample(24'h080000);
   endtask

   task automatic test_random(int count);
      int mode;
      logic [DRIVE_BITS-1:0] drive;
      for (int n = 0; n < count; n += 50) begin
         mode = $urandom_range(0, 7);
         case ($urandom_range(0, 3))
            0: drive = '0;
            1: drive = 17'd65536;
            2: drive = DRIVE_BITS'($urandom);
            default: drive = DRIVE_BITS'($urandom_range(0, 65536));
         endcase
         set_shape(mode, drive);
         for (int i = 0; i < 50; i++) begin
            if (n + i == count / 2) drain_pipeline();
            if (n + i > count * 9 / 10) begin
               sender_idles = 1'b0;
               receiver_idles = 1'b0;
            end
            send_sample(random_sample());
         end
      end
   endtask

   task automatic test_back_to_back();
      set_shape(MODE_ATAN, 17'd20000);
      repeat (60) send_sample(SAMPLE_BITS'($urandom));
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
         end else if (receiver_idles && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(0, 14);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      shaped_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_shapes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %h/%b", rsp_tdata, rsp_tuser);
         end else begin
            want = expected_shapes.pop_front();
            if (rsp_tdata !== want.sample || rsp_tuser[0] !== want.clipped) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h/%b, actual %h/%b",
                     want.sample, want.clipped, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   initial begin
      drive_reg = '0;
      mode_reg = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1450);
      test_back_to_back();
      drain_pipeline();
      if (mismatches == 0 && expected_shapes.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #400000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

@@ filelist.f @@
src/mmds_pkg.sv
src/mmds_mulq.sv
src/multi_mode_distortion_shaper.sv
dv/tb_multi_mode_distortion_shaper.sv
